@@ src/siml_pkg.sv @@
package siml_pkg;

  localparam int unsigned MaxIntervalsDef = 64;
  localparam int unsigned HeightWidthDef  = 24;

  localparam int unsigned StatusWidth   = 3;
  localparam int unsigned PositionWidth = 6;
  localparam int unsigned CountWidth    = 7;
  localparam int unsigned MassWidth     = 32;

  typedef enum logic [StatusWidth-1:0] {
    STAT_INSERTED = 3'd0,
    STAT_MERGED   = 3'd1,
    STAT_FULL     = 3'd2,
    STAT_BAD_ORD  = 3'd3,
    STAT_READ_OK  = 3'd4,
    STAT_READ_OOR = 3'd5
  } status_e;

  typedef enum logic [1:0] {
    KIND_ADD,
    KIND_READ,
    KIND_BAD
  } kind_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_RD_WAIT,
    S_SCAN_RD,
    S_SCAN_EV,
    S_INS_DEC,
    S_SHF_RD,
    S_SHF_WR,
    S_INS_WR,
    S_ABS_RD,
    S_ABS_EV,
    S_MRG_WR,
    S_CMP_RD,
    S_CMP_WR,
    S_MRG_FIN,
    S_DONE
  } state_e;

  typedef struct packed {
    kind_e                    kind;
    logic                     sel;
    logic [PositionWidth-1:0] ridx;
  } cmd_t;

endpackage

@@ src/siml_if.sv @@
interface siml_in_if #(
  parameter int unsigned HW = 24
);
  logic          valid;
  logic          ready;
  logic          command;
  logic          list_select;
  logic [HW-1:0] bottom;
  logic [HW-1:0] upper;
  logic [5:0]    read_index;

  modport source (output valid, command, list_select, bottom, upper, read_index,
                  input ready);
  modport sink (input valid, command, list_select, bottom, upper, read_index,
                output ready);
endinterface

interface siml_out_if #(
  parameter int unsigned HW = 24
);
  logic          valid;
  logic          ready;
  logic [2:0]    status;
  logic [5:0]    position;
  logic [6:0]    entry_count;
  logic [HW-1:0] entry_bottom;
  logic [HW-1:0] entry_upper;
  logic [31:0]   entry_mass;

  modport source (output valid, status, position, entry_count, entry_bottom,
                  entry_upper, entry_mass, input ready);
  modport sink (input valid, status, position, entry_count, entry_bottom,
                entry_upper, entry_mass, output ready);
endinterface

@@ src/sorted_interval_merge_list_core.sv @@
// Sorted interval merge list: two sorted lists (chosen by list_select) of
// bottom/top/mass intervals in one shared single-port-write RAM. A front queue
// (two items) accepts and classifies items; a back sequencer executes them one
// at a time and places the result in an output register, so a new item can be
// queued while a result waits. Each memory read is issued, then its registered
// data is used. An add scans entries until its place, then either shifts the
// tail up one slot to insert or absorbs touching entries and compacts the tail
// down. No clearing pass runs after reset.
module sorted_interval_merge_list_core #(
  parameter int unsigned MAX_INTERVALS = siml_pkg::MaxIntervalsDef,
  parameter int unsigned HEIGHT_WIDTH  = siml_pkg::HeightWidthDef
) (
  input logic clk_i,
  input logic rst_ni,
  siml_in_if.sink    in_i,
  siml_out_if.source out_o
);
  import siml_pkg::*;

  localparam int unsigned AW = $clog2(2 * MAX_INTERVALS);
  localparam int unsigned DW = 2 * HEIGHT_WIDTH + 32;

  logic                    cmd_valid, cmd_pop;
  cmd_t                    cmd;
  logic [HEIGHT_WIDTH-1:0] bot, top;
  logic                    we, re;
  logic [AW-1:0]           waddr, raddr;
  logic [DW-1:0]           wdata, rdata;

  siml_front #(.HW(HEIGHT_WIDTH)) u_front (
    .clk_i, .rst_ni, .in_i,
    .cmd_valid_o(cmd_valid), .cmd_pop_i(cmd_pop), .cmd_o(cmd),
    .bot_o(bot), .top_o(top)
  );

  siml_ram #(.WIDTH(DW), .DEPTH(2 * MAX_INTERVALS)) u_ram (
    .clk_i, .we_i(we), .waddr_i(waddr), .wdata_i(wdata),
    .re_i(re), .raddr_i(raddr), .rdata_o(rdata)
  );

  siml_back #(.MAX_INTERVALS(MAX_INTERVALS), .HW(HEIGHT_WIDTH)) u_back (
    .clk_i, .rst_ni,
    .cmd_valid_i(cmd_valid), .cmd_pop_o(cmd_pop), .cmd_i(cmd),
    .bot_i(bot), .top_i(top),
    .we_o(we), .waddr_o(waddr), .wdata_o(wdata),
    .re_o(re), .raddr_o(raddr), .rdata_i(rdata),
    .out_o
  );
endmodule

@@ src/siml_ram.sv @@
module siml_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end
endmodule

@@ src/siml_front.sv @@
module siml_front #(
  parameter int unsigned HW = siml_pkg::HeightWidthDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  siml_in_if.sink             in_i,
  output logic                cmd_valid_o,
  input  logic                cmd_pop_i,
  output siml_pkg::cmd_t      cmd_o,
  output logic [HW-1:0]       bot_o,
  output logic [HW-1:0]       top_o
);
  import siml_pkg::*;

  cmd_t          cmd_q [2];
  logic [HW-1:0] bot_q [2];
  logic [HW-1:0] top_q [2];
  logic          wp_q, rp_q;
  logic [1:0]    cnt_q;
  logic          push, pop;
  cmd_t          cls;

  // classify on entry so the back end only branches on kind
  always_comb begin
    cls.sel  = in_i.list_select;
    cls.ridx = in_i.read_index;
    if (in_i.command) begin
      cls.kind = KIND_READ;
    end else if ($signed(in_i.bottom) > $signed(in_i.upper)) begin
      cls.kind = KIND_BAD;
    end else begin
      cls.kind = KIND_ADD;
    end
  end

  assign in_i.ready  = (cnt_q != 2'd2);
  assign push        = in_i.valid && in_i.ready;
  assign pop         = cmd_pop_i && (cnt_q != 2'd0);
  assign cmd_valid_o = (cnt_q != 2'd0);
  assign cmd_o       = cmd_q[rp_q];
  assign bot_o       = bot_q[rp_q];
  assign top_o       = top_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (push) begin
      cmd_q[wp_q] <= cls;
      bot_q[wp_q] <= in_i.bottom;
      top_q[wp_q] <= in_i.upper;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push) wp_q <= ~wp_q;
      if (pop) rp_q <= ~rp_q;
      cnt_q <= cnt_q + 2'(push) - 2'(pop);
    end
  end
endmodule

@@ src/siml_back.sv @@
module siml_back #(
  parameter int unsigned MAX_INTERVALS = siml_pkg::MaxIntervalsDef,
  parameter int unsigned HW            = siml_pkg::HeightWidthDef,
  localparam int unsigned CW = $clog2(MAX_INTERVALS + 1),
  localparam int unsigned AW = $clog2(2 * MAX_INTERVALS),
  localparam int unsigned DW = 2 * HW + 32
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           cmd_valid_i,
  output logic           cmd_pop_o,
  input  siml_pkg::cmd_t cmd_i,
  input  logic [HW-1:0]  bot_i,
  input  logic [HW-1:0]  top_i,
  output logic           we_o,
  output logic [AW-1:0]  waddr_o,
  output logic [DW-1:0]  wdata_o,
  output logic           re_o,
  output logic [AW-1:0]  raddr_o,
  input  logic [DW-1:0]  rdata_i,
  siml_out_if.source     out_o
);
  import siml_pkg::*;

  localparam logic [33:0] MassMax = 34'h0_FFFF_FFFF;

  state_e state_q, state_d;
  logic [CW-1:0] cnt_q [2];
  logic [CW-1:0] n_q, n_d, idx_q, idx_d, i_q, i_d, k_q, k_d, d_q, d_d;
  logic          sel_q, sel_d;
  logic [HW-1:0] bot_q, bot_d, top_q, top_d, nb_q, nb_d, nt_q, nt_d, lu_q, lu_d;
  logic [31:0]   m_q, m_d;
  status_e       rs_q, rs_d;
  logic [CW-1:0] rp_q, rp_d, rn_q, rn_d;
  logic [HW-1:0] rb_q, rb_d, rt_q, rt_d;
  logic [31:0]   rm_q, rm_d;
  logic          cnt_we;
  logic          ov_q;
  logic          load_out;

  logic signed [HW-1:0] r_lo, r_up;
  logic [31:0]          r_ms;
  logic [HW:0]          diff;
  logic [33:0]          sum;
  logic [AW-1:0]        base;

  assign r_lo = rdata_i[DW-1 -: HW];
  assign r_up = rdata_i[DW-HW-1 -: HW];
  assign r_ms = rdata_i[31:0];
  assign diff = {top_q[HW-1], top_q} - {bot_q[HW-1], bot_q};
  assign base = sel_q ? AW'(MAX_INTERVALS) : '0;

  function automatic logic [31:0] sat(input logic [33:0] s);
    sat = (s > MassMax) ? 32'hFFFF_FFFF : s[31:0];
  endfunction

  always_comb begin
    state_d = state_q;
    n_d = n_q; idx_d = idx_q; i_d = i_q; k_d = k_q; d_d = d_q;
    sel_d = sel_q; bot_d = bot_q; top_d = top_q;
    nb_d = nb_q; nt_d = nt_q; lu_d = lu_q; m_d = m_q;
    rs_d = rs_q; rp_d = rp_q; rn_d = rn_q; rb_d = rb_q; rt_d = rt_q; rm_d = rm_q;
    cnt_we = 1'b0;
    cmd_pop_o = 1'b0;
    we_o = 1'b0; waddr_o = '0; wdata_o = '0;
    re_o = 1'b0; raddr_o = '0;
    load_out = 1'b0;
    sum = '0;
    case (state_q)
      S_IDLE: begin
        if (cmd_valid_i) begin
          cmd_pop_o = 1'b1;
          sel_d = cmd_i.sel;
          bot_d = bot_i;
          top_d = top_i;
          n_d   = cnt_q[cmd_i.sel];
          rn_d  = cnt_q[cmd_i.sel];
          rb_d = '0; rt_d = '0; rm_d = '0;
          idx_d = '0;
          rp_d  = '0;
          case (cmd_i.kind)
            KIND_READ: begin
              rp_d = CW'(cmd_i.ridx);
              if (32'(cmd_i.ridx) >= 32'(cnt_q[cmd_i.sel])) begin
                rs_d = STAT_READ_OOR;
                state_d = S_DONE;
              end else begin
                re_o    = 1'b1;
                raddr_o = AW'(cmd_i.ridx) + (cmd_i.sel ? AW'(MAX_INTERVALS) : '0);
                rs_d    = STAT_READ_OK;
                state_d = S_RD_WAIT;
              end
            end
            KIND_BAD: begin
              rs_d = STAT_BAD_ORD;
              state_d = S_DONE;
            end
            default: state_d = S_SCAN_RD;
          endcase
        end
      end
      S_RD_WAIT: begin
        rb_d = r_lo; rt_d = r_up; rm_d = r_ms;
        state_d = S_DONE;
      end
      S_SCAN_RD: begin
        i_d = idx_q;
        if (idx_q == n_q) begin
          state_d = S_INS_DEC;
        end else begin
          re_o = 1'b1;
          raddr_o = base + AW'(idx_q);
          state_d = S_SCAN_EV;
        end
      end
      S_SCAN_EV: begin
        if ($signed(top_q) < r_lo) begin
          state_d = S_INS_DEC;
        end else if ($signed(bot_q) <= r_up) begin
          nb_d = ($signed(bot_q) < r_lo) ? bot_q : r_lo;
          nt_d = ($signed(top_q) > r_up) ? top_q : r_up;
          lu_d = r_up;
          sum  = {2'b00, r_ms} + {1'b0, 33'(diff)};
          m_d  = sat(sum);
          k_d  = idx_q + 1'b1;
          state_d = S_ABS_RD;
        end else begin
          idx_d = idx_q + 1'b1;
          state_d = S_SCAN_RD;
        end
      end
      S_INS_DEC: begin
        rp_d = i_q;
        if (32'(n_q) >= MAX_INTERVALS) begin
          rs_d = STAT_FULL;
          state_d = S_DONE;
        end else begin
          k_d = n_q;
          state_d = (n_q == i_q) ? S_INS_WR : S_SHF_RD;
        end
      end
      S_SHF_RD: begin
        re_o = 1'b1;
        raddr_o = base + AW'(k_q - 1'b1);
        state_d = S_SHF_WR;
      end
      S_SHF_WR: begin
        we_o = 1'b1;
        waddr_o = base + AW'(k_q);
        wdata_o = rdata_i;
        k_d = k_q - 1'b1;
        state_d = (k_q - 1'b1 == i_q) ? S_INS_WR : S_SHF_RD;
      end
      S_INS_WR: begin
        we_o = 1'b1;
        waddr_o = base + AW'(i_q);
        wdata_o = {bot_q, top_q, sat({1'b0, 33'(diff)})};
        n_d = n_q + 1'b1;
        cnt_we = 1'b1;
        rs_d = STAT_INSERTED;
        rn_d = n_q + 1'b1;
        rb_d = bot_q; rt_d = top_q; rm_d = sat({1'b0, 33'(diff)});
        state_d = S_DONE;
      end
      S_ABS_RD: begin
        if (k_q == n_q) begin
          state_d = S_MRG_WR;
        end else begin
          re_o = 1'b1;
          raddr_o = base + AW'(k_q);
          state_d = S_ABS_EV;
        end
      end
      S_ABS_EV: begin
        if ($signed(top_q) >= r_lo) begin
          sum = {2'b00, m_q} + {2'b00, r_ms};
          m_d = sat(sum);
          lu_d = r_up;
          k_d = k_q + 1'b1;
          state_d = S_ABS_RD;
        end else begin
          state_d = S_MRG_WR;
        end
      end
      S_MRG_WR: begin
        // k_q is one past the last absorbed entry
        nt_d = ($signed(lu_q) > $signed(nt_q)) ? lu_q : nt_q;
        we_o = 1'b1;
        waddr_o = base + AW'(i_q);
        wdata_o = {nb_q, nt_d, m_q};
        d_d = i_q + 1'b1;
        idx_d = k_q;
        state_d = (k_q == n_q) ? S_MRG_FIN : S_CMP_RD;
      end
      S_CMP_RD: begin
        re_o = 1'b1;
        raddr_o = base + AW'(k_q);
        state_d = S_CMP_WR;
      end
      S_CMP_WR: begin
        we_o = 1'b1;
        waddr_o = base + AW'(d_q);
        wdata_o = rdata_i;
        k_d = k_q + 1'b1;
        d_d = d_q + 1'b1;
        state_d = (k_q + 1'b1 == n_q) ? S_MRG_FIN : S_CMP_RD;
      end
      S_MRG_FIN: begin
        n_d = n_q - (idx_q - i_q - 1'b1);
        cnt_we = 1'b1;
        rs_d = STAT_MERGED;
        rp_d = i_q;
        rn_d = n_q - (idx_q - i_q - 1'b1);
        rb_d = nb_q; rt_d = nt_q; rm_d = m_q;
        state_d = S_DONE;
      end
      S_DONE: begin
        if (!ov_q || out_o.ready) begin
          load_out = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    n_q <= n_d; idx_q <= idx_d; i_q <= i_d; k_q <= k_d; d_q <= d_d;
    sel_q <= sel_d; bot_q <= bot_d; top_q <= top_d;
    nb_q <= nb_d; nt_q <= nt_d; lu_q <= lu_d; m_q <= m_d;
    rs_q <= rs_d; rp_q <= rp_d; rn_q <= rn_d; rb_q <= rb_d; rt_q <= rt_d; rm_q <= rm_d;
    if (load_out) begin
      out_o.status       <= rs_q;
      out_o.position     <= PositionWidth'(rp_q);
      out_o.entry_count  <= CountWidth'(rn_q);
      out_o.entry_bottom <= rb_q;
      out_o.entry_upper  <= rt_q;
      out_o.entry_mass   <= rm_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q[0] <= '0;
      cnt_q[1] <= '0;
      ov_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cnt_we) cnt_q[sel_q] <= n_d;
      if (load_out) ov_q <= 1'b1;
      else if (out_o.ready) ov_q <= 1'b0;
    end
  end

  assign out_o.valid = ov_q;

`ifndef SYNTHESIS
  a_cnt0_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(cnt_q[0]) <= MAX_INTERVALS) else $error("list 0 count above capacity");
  a_cnt1_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(cnt_q[1]) <= MAX_INTERVALS) else $error("list 1 count above capacity");
  a_scan_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN_EV || state_q == S_ABS_EV) |-> (idx_q < n_q || k_q < n_q))
    else $error("scan index past list end");
  a_done_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DONE && !ov_q) |=> (ov_q && state_q == S_IDLE))
    else $error("result not handed to output register");
`endif
endmodule

@@ test/tb_scoreboard.sv @@
`timescale 1ns / 1ps

class interval_scoreboard;
  localparam int unsigned Slots = 64;

  typedef struct packed {
    logic [2:0]  status;
    logic [5:0]  position;
    logic [6:0]  entry_count;
    logic [23:0] entry_bottom;
    logic [23:0] entry_upper;
    logic [31:0] entry_mass;
  } outcome_t;

  int  lo_q [2][Slots];
  int  hi_q [2][Slots];
  int unsigned mass_q [2][Slots];
  int unsigned cnt [2];
  outcome_t pending [$];
  int  mismatches;

  function new();
    cnt[0] = 0;
    cnt[1] = 0;
    mismatches = 0;
  endfunction

  static function int unsigned add_sat(int unsigned a, longint unsigned b);
    longint unsigned s;
    s = longint'(a) + b;
    return (s > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : s[31:0];
  endfunction

  // Apply one accepted item to the shadow lists and queue its outcome.
  function void note_item(bit rd, bit sel, logic [23:0] b_raw, logic [23:0] u_raw,
                          logic [5:0] ridx);
    outcome_t o;
    int bot, top, nb, nt, i, c, stop, k, n;
    int unsigned m;
    bit hit;
    bot = $signed(b_raw);
    top = $signed(u_raw);
    n = cnt[sel];
    o = '0;
    hit = 0;
    if (rd) begin
      o.position = ridx;
      o.entry_count = n;
      if (ridx >= n) begin
        o.status = siml_pkg::STAT_READ_OOR;
      end else begin
        o.status = siml_pkg::STAT_READ_OK;
        o.entry_bottom = lo_q[sel][ridx];
        o.entry_upper = hi_q[sel][ridx];
        o.entry_mass = mass_q[sel][ridx];
      end
      pending.insert(pending.size(), o);
      return;
    end
    o.entry_count = n;
    if (bot > top) begin
      o.status = siml_pkg::STAT_BAD_ORD;
      pending.insert(pending.size(), o);
      return;
    end
    for (i = 0; i < n; i++) begin
      if (top < lo_q[sel][i]) break;
      if (bot <= hi_q[sel][i]) begin
        hit = 1;
        break;
      end
    end
    if (hit) begin
      c = i + 1;
      stop = i + 1;
      while (c < n && top >= lo_q[sel][c]) begin
        c++;
        stop = c;
      end
      nb = (bot < lo_q[sel][i]) ? bot : lo_q[sel][i];
      nt = (top > hi_q[sel][i]) ? top : hi_q[sel][i];
      if (hi_q[sel][stop-1] > nt) nt = hi_q[sel][stop-1];
      m = add_sat(mass_q[sel][i], longint'(top) - longint'(bot));
      for (k = i + 1; k < stop; k++) m = add_sat(m, mass_q[sel][k]);
      lo_q[sel][i] = nb;
      hi_q[sel][i] = nt;
      mass_q[sel][i] = m;
      for (k = stop; k < n; k++) begin
        lo_q[sel][i+1+k-stop] = lo_q[sel][k];
        hi_q[sel][i+1+k-stop] = hi_q[sel][k];
        mass_q[sel][i+1+k-stop] = mass_q[sel][k];
      end
      n -= stop - (i + 1);
      cnt[sel] = n;
      o.status = siml_pkg::STAT_MERGED;
      o.position = i;
      o.entry_count = n;
      o.entry_bottom = nb;
      o.entry_upper = nt;
      o.entry_mass = m;
    end else if (n >= Slots) begin
      o.status = siml_pkg::STAT_FULL;
      o.position = i;
    end else begin
      for (k = n; k > i; k--) begin
        lo_q[sel][k] = lo_q[sel][k-1];
        hi_q[sel][k] = hi_q[sel][k-1];
        mass_q[sel][k] = mass_q[sel][k-1];
      end
      lo_q[sel][i] = bot;
      hi_q[sel][i] = top;
      mass_q[sel][i] = top - bot;
      cnt[sel] = n + 1;
      o.status = siml_pkg::STAT_INSERTED;
      o.position = i;
      o.entry_count = n + 1;
      o.entry_bottom = bot;
      o.entry_upper = top;
      o.entry_mass = top - bot;
    end
    pending.insert(pending.size(), o);
  endfunction

  function void check_result(outcome_t got);
    outcome_t exp_o;
    if (pending.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("unexpected result %h", got);
      return;
    end
    exp_o = pending.pop_front();
    if (got !== exp_o) begin
      mismatches++;
      if (mismatches <= 10) begin
        $display("mismatch: exp st=%0d pos=%0d cnt=%0d b=%h u=%h m=%h",
                 exp_o.status, exp_o.position, exp_o.entry_count, exp_o.entry_bottom,
                 exp_o.entry_upper, exp_o.entry_mass);
        $display("          got st=%0d pos=%0d cnt=%0d b=%h u=%h m=%h",
                 got.status, got.position, got.entry_count, got.entry_bottom,
                 got.entry_upper, got.entry_mass);
      end
    end
  endfunction
endclass

@@ test/tb.sv @@
`timescale 1ns / 1ps

module tb;
  localparam int unsigned StallLimit = 20000;

  logic clk_i = 0;
  logic rst_ni = 0;
  always #5 clk_i = ~clk_i;

  siml_in_if  #(.HW(24)) in_if ();
  siml_out_if #(.HW(24)) out_if ();

  sorted_interval_merge_list_core u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if.sink),
    .out_o  (out_if.source)
  );

  interval_scoreboard lists = new();
  bit hold_off = 0;
  bit rx_long = 0;
  int idle_cycles = 0;

  initial begin
    in_if.valid = 0;
    in_if.command = 0;
    in_if.list_select = 0;
    in_if.bottom = '0;
    in_if.upper = '0;
    in_if.read_index = '0;
    out_if.ready = 0;
  end

  // Receiver: mixed stall pattern, plus a long hold-off on request.
  always @(posedge clk_i) begin
    if (rx_long) out_if.ready <= 0;
    else if (hold_off) out_if.ready <= 1;
    else out_if.ready <= ($urandom_range(0, 3) != 0);
  end

  always @(posedge clk_i) begin
    if (rst_ni && in_if.valid && in_if.ready)
      lists.note_item(in_if.command, in_if.list_select, in_if.bottom, in_if.upper,
                      in_if.read_index);
    if (rst_ni && out_if.valid && out_if.ready)
      lists.check_result({out_if.status, out_if.position, out_if.entry_count,
                          out_if.entry_bottom, out_if.entry_upper, out_if.entry_mass});
  end

  always @(posedge clk_i) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) || rx_long)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= StallLimit) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  task automatic send_item(bit rd, bit sel, logic [23:0] b, logic [23:0] u, logic [5:0] r);
    in_if.valid <= 1;
    in_if.command <= rd;
    in_if.list_select <= sel;
    in_if.bottom <= b;
    in_if.upper <= u;
    in_if.read_index <= r;
    do @(posedge clk_i); while (!in_if.ready);
  endtask

  task automatic gap(int n);
    if (n > 0) begin
      in_if.valid <= 0;
      repeat (n) @(posedge clk_i);
    end
  endtask

  task automatic drain();
    gap(1);
    while (lists.pending.size() != 0) @(posedge clk_i);
  endtask

  // Random add: mostly narrow intervals in a small window so merges happen.
  task automatic rand_add(bit sel, int span);
    int b, w;
    b = $urandom_range(0, span) - span / 2;
    w = $urandom_range(0, 7) == 0 ? $urandom_range(0, span / 4) : $urandom_range(0, 40);
    send_item(0, sel, b, b + w, $urandom);
  endtask

  task automatic rand_item();
    int k;
    k = $urandom_range(0, 19);
    if (k < 11) rand_add($urandom_range(0, 1), ($urandom_range(0, 1) ? 4000 : 400000));
    else if (k < 16) send_item(1, $urandom_range(0, 1), $urandom, $urandom,
                               $urandom_range(0, 63));
    else if (k < 18) send_item(0, $urandom_range(0, 1), $urandom, $urandom, $urandom);
    else rand_add($urandom_range(0, 1), 8000000);
  endtask

  initial begin
    int n, burst;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);
    // directed: extremes, bad order, touching endpoints, reads
    send_item(1, 0, 0, 0, 0);
    send_item(0, 0, 24'h800000, 24'h7FFFFF, 6'h3F);
    send_item(0, 1, 24'h800000, 24'h800000, 0);
    send_item(0, 1, 24'h7FFFFF, 24'h7FFFFF, 0);
    send_item(0, 1, 24'h000010, 24'h00000F, 0);
    send_item(0, 1, 24'h7FFFFF, 24'h800000, 0);
    send_item(0, 1, 24'h800000, 24'h7FFFFF, 0);
    repeat (3) send_item(0, 0, 24'h800000, 24'h7FFFFF, 0);
    send_item(0, 0, 24'h800000, 24'h7FFFFF, 0);
    send_item(1, 0, 0, 0, 0);
    send_item(1, 1, 0, 0, 1);
    send_item(1, 1, 0, 0, 6'h3F);
    drain();
    // send 64 disjoint intervals to list 1, which merge into its full-range entry
    for (int j = 0; j < 64; j++) send_item(0, 1, 2000 + j * 10, 2000 + j * 10 + 3, 0);
    send_item(0, 1, 100, 200, 0);
    send_item(0, 1, 2005, 2005, 0);
    send_item(0, 1, 2001, 2012, 0);
    send_item(1, 1, 0, 0, 6'h3F);
    send_item(1, 1, 0, 0, 62);
    // long receiver hold-off while sender keeps offering
    hold_off = 1;
    fork
      begin
        rx_long = 1;
        repeat (3000) @(posedge clk_i);
        rx_long = 0;
      end
      repeat (10) rand_item();
    join
    hold_off = 0;
    drain();
    n = 0;
    while (n < 900) begin
      burst = $urandom_range(1, 30);
      for (int j = 0; j < burst && n < 900; j++) begin
        rand_item();
        n++;
      end
      gap($urandom_range(0, 3) == 0 ? $urandom_range(1, 200) : $urandom_range(0, 5));
    end
    drain();
    repeat (600) @(posedge clk_i);
    if (lists.mismatches == 0 && lists.pending.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end
endmodule
